@@ src/rms_current_power_meter_top_macros.svh @@
// ----------------------------------------------------------------------------
// RMS current meter assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef RMS_CURRENT_POWER_METER_TOP_MACROS_SVH
`define RMS_CURRENT_POWER_METER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RCPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define RCPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RCPM_ASSERT_IMP(lbl, ante, cons, msg)
`define RCPM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/rcpm_pkg.sv @@
// ----------------------------------------------------------------------------
// RMS current meter package
// Widths, limits, register indexes and shared types of the meter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpm_pkg;

  localparam int unsigned MaxWindow = 4096;

  localparam int unsigned SampleW  = 13;
  localparam int unsigned OffsetW  = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned CorrW    = 10;
  localparam int unsigned VoltW    = 9;
  localparam int unsigned WinW     = 13;
  localparam int unsigned DiffW    = 18;
  localparam int unsigned SqW      = 36;
  localparam int unsigned SumW     = 48;
  localparam int unsigned RootW    = 24;
  localparam int unsigned SremW    = 27;
  localparam int unsigned ProdW    = 40;
  localparam int unsigned CurW     = 21;
  localparam int unsigned PwrW     = 30;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 56;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QCntW  = 2;

  localparam int unsigned DivSteps  = 48;
  localparam int unsigned SqrtSteps = 24;
  localparam int unsigned StepW     = 6;

  localparam int unsigned RoundBias = 2048;
  localparam int unsigned ScaleSh   = 12;
  localparam int unsigned CurUMax   = 1049599;
  localparam int unsigned CurMax    = 1048575;
  localparam int          PwrMin    = -524288;
  localparam int          PwrMax    = 536870911;

  localparam logic [OffsetW-1:0] OffsetRst = 16'd7688;
  localparam logic [GainW-1:0]   GainRst   = 16'd11829;
  localparam logic [CorrW-1:0]   CorrRst   = 10'd45;
  localparam logic [VoltW-1:0]   VoltRst   = 9'd240;
  localparam logic [WinW-1:0]    WinRst    = 13'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    RegOffset = 3'd0,
    RegGain   = 3'd1,
    RegCorr   = 3'd2,
    RegVolt   = 3'd3,
    RegWindow = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [WinW-1:0] count;
  } win_sum_t;

  typedef struct packed {
    logic [QCntW-1:0] level;
    logic             full;
    logic             empty;
  } q_stat_t;

  typedef struct packed {
    logic [GainW-1:0] gain;
    logic [CorrW-1:0] corr;
    logic [VoltW-1:0] volt;
  } back_cfg_t;

endpackage

`default_nettype wire

@@ src/rcpm_front.sv @@
// ----------------------------------------------------------------------------
// RMS current meter front end
// Takes samples, removes the offset, squares and sums them over a window and
// hands each finished window sum to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpm_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [rcpm_pkg::SampleW-1:0] sample_i,
  input  wire logic [rcpm_pkg::OffsetW-1:0]       offset_i,
  input  wire logic [rcpm_pkg::WinW-1:0]          win_eff_i,
  input  wire rcpm_pkg::q_stat_t                  q_stat_i,
  output logic                                    push_o,
  output rcpm_pkg::win_sum_t                      push_data_o
);

  logic                                accept;
  logic [rcpm_pkg::WinW-1:0]           cnt_q, cnt_d, cnt_inc;
  logic                                last;
  logic signed [rcpm_pkg::DiffW-1:0]   diff;
  logic [rcpm_pkg::SqW-1:0]            sq_d, sq_q;
  logic                                vld_q, last_q;
  logic [rcpm_pkg::WinW-1:0]           cnt_b_q;
  logic [rcpm_pkg::SumW-1:0]           sum_q, sum_d, sum_n;
  logic [rcpm_pkg::QCntW-1:0]          committed;

  assign committed  = q_stat_i.level + rcpm_pkg::QCntW'(vld_q & last_q);
  assign in_ready_o = committed < rcpm_pkg::QCntW'(rcpm_pkg::QDepth);
  assign accept     = in_valid_i & in_ready_o;

  assign cnt_inc = cnt_q + 1'b1;
  assign last    = cnt_inc >= win_eff_i;
  assign cnt_d   = accept ? (last ? '0 : cnt_inc) : cnt_q;

  assign diff = (rcpm_pkg::DiffW'(sample_i) <<< 4) - $signed({2'b00, offset_i});
  assign sq_d = rcpm_pkg::SqW'(diff * diff);

  assign sum_n       = sum_q + rcpm_pkg::SumW'(sq_q);
  assign sum_d       = vld_q ? (last_q ? '0 : sum_n) : sum_q;
  assign push_o      = vld_q & last_q;
  assign push_data_o = '{sum: sum_n, count: cnt_b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      vld_q  <= 1'b0;
      last_q <= 1'b0;
      sum_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      vld_q  <= accept;
      last_q <= accept & last;
      sum_q  <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q    <= sq_d;
      cnt_b_q <= cnt_inc;
    end
  end

endmodule

`default_nettype wire

@@ src/rcpm_queue.sv @@
// ----------------------------------------------------------------------------
// RMS current meter window queue
// Two-entry register queue of finished window sums between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpm_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire rcpm_pkg::win_sum_t push_data_i,
  input  wire logic               pop_i,
  output rcpm_pkg::win_sum_t      pop_data_o,
  output rcpm_pkg::q_stat_t       stat_o
);

  rcpm_pkg::win_sum_t               mem_q [rcpm_pkg::QDepth];
  logic                             wr_q, rd_q;
  logic [rcpm_pkg::QCntW-1:0]       level_q, level_d;

  assign pop_data_o   = mem_q[rd_q];
  assign stat_o.level = level_q;
  assign stat_o.full  = level_q == rcpm_pkg::QCntW'(rcpm_pkg::QDepth);
  assign stat_o.empty = level_q == '0;

  always_comb begin
    level_d = level_q;
    if (push_i && !pop_i) begin
      level_d = level_q + 1'b1;
    end else if (pop_i && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      level_q <= '0;
    end else begin
      level_q <= level_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ src/rcpm_back.sv @@
// ----------------------------------------------------------------------------
// RMS current meter back end
// Divides a window sum by its count, takes the square root, scales to mA and
// mVA and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcpm_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rcpm_pkg::q_stat_t           q_stat_i,
  input  wire rcpm_pkg::win_sum_t          pop_data_i,
  output logic                             pop_o,
  input  wire rcpm_pkg::back_cfg_t         cfg_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [rcpm_pkg::CurW-1:0] cur_o,
  output logic signed [rcpm_pkg::PwrW-1:0] pwr_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StSqrt  = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StScale = 3'd4;
  localparam logic [2:0] StPower = 3'd5;
  localparam logic [2:0] StHold  = 3'd6;

  logic [2:0]                        state_q, state_d;
  logic [rcpm_pkg::StepW-1:0]        step_q, step_d;
  logic [rcpm_pkg::SumW-1:0]         dvd_q, dvd_d;
  logic [rcpm_pkg::WinW-1:0]         rem_q, rem_d, dvs_q, dvs_d;
  logic [rcpm_pkg::SremW-1:0]        srem_q, srem_d;
  logic [rcpm_pkg::RootW-1:0]        root_q, root_d;
  logic [rcpm_pkg::ProdW-1:0]        prod_q, prod_d;
  logic signed [rcpm_pkg::CurW-1:0]  cur_q, cur_d;
  logic signed [rcpm_pkg::PwrW-1:0]  pwr_q, pwr_d;
  logic                              ov_q, ov_d;
  logic signed [rcpm_pkg::CurW-1:0]  ocur_q, ocur_d;
  logic signed [rcpm_pkg::PwrW-1:0]  opwr_q, opwr_d;

  logic [rcpm_pkg::WinW:0]           rem_sh;
  logic                              div_ge;
  logic [rcpm_pkg::SremW-1:0]        srem_sh, trial;
  logic                              sq_ge;
  logic [rcpm_pkg::ProdW-1:0]        rnd;
  logic [rcpm_pkg::CurW-1:0]         cu_c;
  logic signed [rcpm_pkg::CurW:0]    cur_s;
  logic signed [rcpm_pkg::CurW+rcpm_pkg::VoltW:0] pwr_s;

  assign rem_sh  = {rem_q, dvd_q[rcpm_pkg::SumW-1]};
  assign div_ge  = rem_sh >= {1'b0, dvs_q};
  assign srem_sh = {srem_q[rcpm_pkg::SremW-3:0], dvd_q[rcpm_pkg::SumW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign sq_ge   = srem_sh >= trial;

  assign rnd   = prod_q + rcpm_pkg::ProdW'(rcpm_pkg::RoundBias);
  assign cu_c  = (rnd[rcpm_pkg::ProdW-1:rcpm_pkg::ScaleSh] >
                  (rcpm_pkg::ProdW - rcpm_pkg::ScaleSh)'(rcpm_pkg::CurUMax)) ?
                 rcpm_pkg::CurW'(rcpm_pkg::CurUMax) :
                 rnd[rcpm_pkg::ScaleSh +: rcpm_pkg::CurW];
  assign cur_s = $signed({1'b0, cu_c}) - $signed((rcpm_pkg::CurW+1)'(cfg_i.corr));
  assign pwr_s = cur_q * $signed({1'b0, cfg_i.volt});

  assign pop_o       = (state_q == StIdle) && !q_stat_i.empty;
  assign out_valid_o = ov_q;
  assign cur_o       = ocur_q;
  assign pwr_o       = opwr_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    srem_d  = srem_q;
    root_d  = root_q;
    prod_d  = prod_q;
    cur_d   = cur_q;
    pwr_d   = pwr_q;
    ov_d    = ov_q & ~out_ready_i;
    ocur_d  = ocur_q;
    opwr_d  = opwr_q;
    unique case (state_q)
      StIdle: begin
        if (!q_stat_i.empty) begin
          dvd_d   = pop_data_i.sum;
          dvs_d   = pop_data_i.count;
          rem_d   = '0;
          step_d  = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        rem_d  = div_ge ? rcpm_pkg::WinW'(rem_sh - {1'b0, dvs_q})
                        : rcpm_pkg::WinW'(rem_sh);
        dvd_d  = {dvd_q[rcpm_pkg::SumW-2:0], div_ge};
        step_d = step_q + 1'b1;
        if (step_q == rcpm_pkg::StepW'(rcpm_pkg::DivSteps - 1)) begin
          step_d  = '0;
          srem_d  = '0;
          root_d  = '0;
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        srem_d = sq_ge ? (srem_sh - trial) : srem_sh;
        root_d = {root_q[rcpm_pkg::RootW-2:0], sq_ge};
        dvd_d  = {dvd_q[rcpm_pkg::SumW-3:0], 2'b00};
        step_d = step_q + 1'b1;
        if (step_q == rcpm_pkg::StepW'(rcpm_pkg::SqrtSteps - 1)) begin
          step_d  = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        prod_d  = root_q * cfg_i.gain;
        state_d = StScale;
      end
      StScale: begin
        cur_d   = (cur_s > $signed((rcpm_pkg::CurW+1)'(rcpm_pkg::CurMax))) ?
                  rcpm_pkg::CurW'(rcpm_pkg::CurMax) : rcpm_pkg::CurW'(cur_s);
        state_d = StPower;
      end
      StPower: begin
        if (pwr_s > $signed((rcpm_pkg::CurW+rcpm_pkg::VoltW+1)'(rcpm_pkg::PwrMax))) begin
          pwr_d = rcpm_pkg::PwrW'(rcpm_pkg::PwrMax);
        end else if (pwr_s <
                     $signed((rcpm_pkg::CurW+rcpm_pkg::VoltW+1)'(rcpm_pkg::PwrMin))) begin
          pwr_d = rcpm_pkg::PwrW'(rcpm_pkg::PwrMin);
        end else begin
          pwr_d = rcpm_pkg::PwrW'(pwr_s);
        end
        state_d = StHold;
      end
      StHold: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ocur_d  = cur_q;
          opwr_d  = pwr_q;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    srem_q <= srem_d;
    root_q <= root_d;
    prod_q <= prod_d;
    cur_q  <= cur_d;
    pwr_q  <= pwr_d;
    ocur_q <= ocur_d;
    opwr_q <= opwr_d;
  end

endmodule

`default_nettype wire

@@ src/rms_current_power_meter_top.sv @@
// ----------------------------------------------------------------------------
// RMS current and apparent power meter
// Accepts one signed ADC sample per item and gives RMS current in mA and
// apparent power in mVA at the end of every window.
// ----------------------------------------------------------------------------
// The front end takes one sample every clock cycle unless it is stalled. Each
// window end runs the back end through the queue pop, a 48-step bit-serial
// divide, a 24-step square root, then multiply, scale, power and output load.
// Two finished windows can wait in the queue, so the input stalls only when
// windows end faster than the back end drains them or results are not taken.
`default_nettype none

`include "rms_current_power_meter_top_macros.svh"

module rms_current_power_meter_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // adc_sample [12:0]
  input  wire logic [rcpm_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // current_rms_ma [20:0], apparent_power_mva [50:21]
  output logic [rcpm_pkg::OutDataW-1:0]        m_axis_tdata,
  input  wire logic                            cfg_we_i,
  input  wire logic [rcpm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [rcpm_pkg::CfgDataW-1:0]   cfg_data_i
);

  logic [rcpm_pkg::OffsetW-1:0]      offset_q;
  logic [rcpm_pkg::GainW-1:0]        gain_q;
  logic [rcpm_pkg::CorrW-1:0]        corr_q;
  logic [rcpm_pkg::VoltW-1:0]        volt_q;
  logic [rcpm_pkg::WinW-1:0]         win_q;
  logic [rcpm_pkg::WinW-1:0]         win_eff;
  rcpm_pkg::back_cfg_t               back_cfg;
  rcpm_pkg::q_stat_t                 q_stat;
  rcpm_pkg::win_sum_t                push_data, pop_data;
  logic                              q_push, q_pop;
  logic signed [rcpm_pkg::CurW-1:0]  cur;
  logic signed [rcpm_pkg::PwrW-1:0]  pwr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= rcpm_pkg::OffsetRst;
      gain_q   <= rcpm_pkg::GainRst;
      corr_q   <= rcpm_pkg::CorrRst;
      volt_q   <= rcpm_pkg::VoltRst;
      win_q    <= rcpm_pkg::WinRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rcpm_pkg::RegOffset: offset_q <= cfg_data_i;
        rcpm_pkg::RegGain:   gain_q   <= cfg_data_i;
        rcpm_pkg::RegCorr:   corr_q   <= cfg_data_i[rcpm_pkg::CorrW-1:0];
        rcpm_pkg::RegVolt:   volt_q   <= cfg_data_i[rcpm_pkg::VoltW-1:0];
        rcpm_pkg::RegWindow: win_q    <= cfg_data_i[rcpm_pkg::WinW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (win_q == '0) begin
      win_eff = rcpm_pkg::WinW'(1);
    end else if (win_q > rcpm_pkg::WinW'(rcpm_pkg::MaxWindow)) begin
      win_eff = rcpm_pkg::WinW'(rcpm_pkg::MaxWindow);
    end else begin
      win_eff = win_q;
    end
  end

  assign back_cfg = '{gain: gain_q, corr: corr_q, volt: volt_q};

  rcpm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    ($signed(s_axis_tdata[rcpm_pkg::SampleW-1:0])),
    .offset_i    (offset_q),
    .win_eff_i   (win_eff),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .push_data_o (push_data)
  );

  rcpm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  rcpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_data_i  (pop_data),
    .pop_o       (q_pop),
    .cfg_i       (back_cfg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cur_o       (cur),
    .pwr_o       (pwr)
  );

  assign m_axis_tdata = {5'b00000, pwr, cur};

  `RCPM_ASSERT_IMP(a_push_room, q_push, !q_stat.full, "window pushed into a full queue")
  `RCPM_ASSERT_IMP(a_pop_data, q_pop, !q_stat.empty, "window popped from an empty queue")
  `RCPM_ASSERT_NXT(a_level_up, q_push && !q_pop,
                   q_stat.level == $past(q_stat.level) + 2'd1, "queue level lost a push")

endmodule

`default_nettype wire

@@ tb/rms_meter_monitor.sv @@
// ----------------------------------------------------------------------------
// RMS meter scoreboard
// Watches the sample, result and register ports of the meter, keeps its own
// copy of the window state and the registers, predicts the RMS current and
// apparent power of every finished window and compares each result item
// against the oldest prediction.
// ----------------------------------------------------------------------------
module rms_meter_monitor (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_tvalid_i,
  input  wire logic                               s_tready_i,
  input  wire logic [rcpm_pkg::InDataW-1:0]       s_tdata_i,
  input  wire logic                               m_tvalid_i,
  input  wire logic                               m_tready_i,
  input  wire logic [rcpm_pkg::OutDataW-1:0]      m_tdata_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [rcpm_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [rcpm_pkg::CfgDataW-1:0]      cfg_data_i,
  output int unsigned                             fail_count_o,
  output int unsigned                             readings_left_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [rcpm_pkg::PwrW-1:0] pwr_mva;
    logic signed [rcpm_pkg::CurW-1:0] cur_ma;
  } reading_t;

  logic [rcpm_pkg::OffsetW-1:0] offset_q4;
  logic [rcpm_pkg::GainW-1:0]   gain_q8;
  logic [rcpm_pkg::CorrW-1:0]   corr_ma;
  logic [rcpm_pkg::VoltW-1:0]   volt_v;
  logic [rcpm_pkg::WinW-1:0]    win_len;
  logic [rcpm_pkg::SumW-1:0]    sq_sum;
  logic [rcpm_pkg::WinW-1:0]    n_samples;
  reading_t                     expected_readings[$];
  int unsigned                  failures;

  function automatic logic [rcpm_pkg::RootW-1:0] int_sqrt(logic [rcpm_pkg::SumW-1:0] v);
    logic [rcpm_pkg::RootW-1:0] r;
    logic [rcpm_pkg::RootW-1:0] t;
    r = '0;
    for (int b = rcpm_pkg::RootW - 1; b >= 0; b--) begin
      t = r | (24'd1 << b);
      if (48'(t) * 48'(t) <= v) r = t;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [rcpm_pkg::SampleW-1:0] smp;
    longint                              diff;
    longint unsigned                     sq;
    int unsigned                         eff_win;
    logic [rcpm_pkg::SumW-1:0]           mean;
    longint unsigned                     root;
    longint unsigned                     cur_u;
    longint                              cur_s;
    longint                              pwr_s;
    reading_t                            want;
    logic signed [rcpm_pkg::CurW-1:0]    got_cur;
    logic signed [rcpm_pkg::PwrW-1:0]    got_pwr;
    if (!rst_ni) begin
      offset_q4 = rcpm_pkg::OffsetRst;
      gain_q8   = rcpm_pkg::GainRst;
      corr_ma   = rcpm_pkg::CorrRst;
      volt_v    = rcpm_pkg::VoltRst;
      win_len   = rcpm_pkg::WinRst;
      sq_sum    = '0;
      n_samples = '0;
      expected_readings.delete();
      failures  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rcpm_pkg::RegOffset: offset_q4 = cfg_data_i[rcpm_pkg::OffsetW-1:0];
          rcpm_pkg::RegGain:   gain_q8   = cfg_data_i[rcpm_pkg::GainW-1:0];
          rcpm_pkg::RegCorr:   corr_ma   = cfg_data_i[rcpm_pkg::CorrW-1:0];
          rcpm_pkg::RegVolt:   volt_v    = cfg_data_i[rcpm_pkg::VoltW-1:0];
          rcpm_pkg::RegWindow: win_len   = cfg_data_i[rcpm_pkg::WinW-1:0];
          default: ;
        endcase
      end

      if (m_tvalid_i && m_tready_i) begin
        got_cur = m_tdata_i[rcpm_pkg::CurW-1:0];
        got_pwr = m_tdata_i[rcpm_pkg::CurW +: rcpm_pkg::PwrW];
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, current_rms_ma %0d apparent_power_mva %0d",
                   $time, got_cur, got_pwr);
          failures++;
        end else begin
          want = expected_readings.pop_front();
          if (got_cur !== want.cur_ma) begin
            $display("%0t: current_rms_ma expected %0d actual %0d",
                     $time, want.cur_ma, got_cur);
            failures++;
          end
          if (got_pwr !== want.pwr_mva) begin
            $display("%0t: apparent_power_mva expected %0d actual %0d",
                     $time, want.pwr_mva, got_pwr);
            failures++;
          end
        end
      end

      if (s_tvalid_i && s_tready_i) begin
        smp       = s_tdata_i[rcpm_pkg::SampleW-1:0];
        diff      = longint'(smp) * 16 - longint'(offset_q4);
        sq        = diff * diff;
        sq_sum    = sq_sum + sq[rcpm_pkg::SumW-1:0];
        n_samples = n_samples + 1'b1;
        if (win_len == 0) eff_win = 1;
        else if (win_len > rcpm_pkg::MaxWindow) eff_win = rcpm_pkg::MaxWindow;
        else eff_win = win_len;
        if (n_samples >= eff_win || n_samples == 0) begin
          mean  = (n_samples != 0) ? sq_sum / n_samples : sq_sum;
          root  = int_sqrt(mean);
          cur_u = (root * gain_q8 + 64'd2048) >> 12;
          if (cur_u > rcpm_pkg::CurUMax) cur_u = rcpm_pkg::CurUMax;
          cur_s = cur_u;
          cur_s = cur_s - longint'(corr_ma);
          if (cur_s < -1024) cur_s = -1024;
          if (cur_s > longint'(rcpm_pkg::CurMax)) cur_s = rcpm_pkg::CurMax;
          pwr_s = cur_s * longint'(volt_v);
          if (pwr_s < longint'(rcpm_pkg::PwrMin)) pwr_s = rcpm_pkg::PwrMin;
          if (pwr_s > longint'(rcpm_pkg::PwrMax)) pwr_s = rcpm_pkg::PwrMax;
          want.cur_ma  = cur_s[rcpm_pkg::CurW-1:0];
          want.pwr_mva = pwr_s[rcpm_pkg::PwrW-1:0];
          expected_readings.push_back(want);
          sq_sum    = '0;
          n_samples = '0;
        end
      end
    end
    fail_count_o    <= failures;
    readings_left_o <= expected_readings.size();
  end

endmodule

@@ tb/rms_current_power_meter_top_test.sv @@
// ----------------------------------------------------------------------------
// RMS current meter testbench
// Streams ADC samples into the meter under a range of register settings:
// the reset setting, field and register extremes, short windows, an over-long
// window that is later shortened, a window shortened part-way and random
// phases, with random gaps on both streams and one long result hold-off.
// A scoreboard beside the meter checks every result item.
// ----------------------------------------------------------------------------
module rms_current_power_meter_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rcpm_pkg::CfgIdxW-1:0] RegNone = 3'd7;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned HoldCycles   = 400;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [rcpm_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [rcpm_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          cfg_we_i      = 1'b0;
  logic [rcpm_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [rcpm_pkg::CfgDataW-1:0] cfg_data_i    = '0;

  int unsigned check_failures;
  int unsigned readings_left;
  int unsigned samples_pushed = 0;
  logic        idle_on        = 1'b1;
  logic        hold_off_req   = 1'b0;
  logic        drain_stuck    = 1'b0;
  logic [rcpm_pkg::OffsetW-1:0] offset_now = rcpm_pkg::OffsetRst;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rms_current_power_meter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  rms_meter_monitor scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (check_failures),
    .readings_left_o (readings_left)
  );

  initial begin : result_sink
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int i = 0; i < HoldCycles; i++) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(logic [rcpm_pkg::CfgIdxW-1:0] idx,
                           logic [rcpm_pkg::CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == rcpm_pkg::RegOffset) offset_now = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_sample(logic [rcpm_pkg::SampleW-1:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(rcpm_pkg::InDataW - rcpm_pkg::SampleW){1'b0}}, value};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    samples_pushed++;
  endtask

  task automatic drain();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (readings_left != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (readings_left != 0) drain_stuck = 1'b1;
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [rcpm_pkg::SampleW-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = -4096;
      1: v = 4095;
      2, 3, 4: begin
        v = int'(offset_now >> 4) + int'($urandom_range(0, 16)) - 8;
        if (v > 4095) v = 4095;
      end
      default: v = int'($urandom_range(0, 8191));
    endcase
    return v[rcpm_pkg::SampleW-1:0];
  endfunction

  initial begin : stimulus
    int unsigned base_pushed;
    int unsigned n;
    int unsigned w;
    logic [rcpm_pkg::CfgDataW-1:0] word;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(rcpm_pkg::RegWindow, 16'd16);
    repeat (16) push_sample(pick_sample());
    drain();

    write_reg(rcpm_pkg::RegOffset, 16'h0000);
    write_reg(rcpm_pkg::RegCorr, 16'h0000);
    write_reg(rcpm_pkg::RegVolt, 16'h0001);
    write_reg(rcpm_pkg::RegWindow, 16'h0001);
    push_sample(13'h1000);
    push_sample(13'h0FFF);
    push_sample(13'h0000);
    push_sample(13'h1FFF);
    push_sample(13'h0001);
    push_sample(13'h0AAA);
    push_sample(13'h1555);
    drain();

    write_reg(rcpm_pkg::RegOffset, 16'hFFFF);
    write_reg(rcpm_pkg::RegGain, 16'hFFFF);
    write_reg(rcpm_pkg::RegCorr, 16'hFC00);
    write_reg(rcpm_pkg::RegVolt, 16'hFFFF);
    push_sample(13'h1000);
    push_sample(13'h0FFF);
    drain();

    write_reg(rcpm_pkg::RegCorr, 16'h03FF);
    write_reg(rcpm_pkg::RegGain, 16'h0001);
    push_sample(13'h0000);
    push_sample(13'h0064);
    drain();

    write_reg(rcpm_pkg::RegWindow, 16'hE000);
    push_sample(13'h0123);
    push_sample(13'h1F00);
    drain();

    write_reg(rcpm_pkg::RegOffset, rcpm_pkg::OffsetRst);
    write_reg(rcpm_pkg::RegGain, rcpm_pkg::GainRst);
    write_reg(rcpm_pkg::RegCorr, 16'(rcpm_pkg::CorrRst));
    write_reg(rcpm_pkg::RegVolt, 16'(rcpm_pkg::VoltRst));
    write_reg(rcpm_pkg::RegWindow, 16'd8);
    repeat (5) push_sample(pick_sample());
    drain();
    write_reg(RegNone, 16'hFFFF);
    write_reg(rcpm_pkg::RegWindow, 16'd3);
    push_sample(pick_sample());
    drain();

    write_reg(rcpm_pkg::RegWindow, 16'hFFFF);
    repeat (100) push_sample(pick_sample());
    drain();
    write_reg(rcpm_pkg::RegWindow, 16'd3);
    push_sample(pick_sample());
    drain();

    write_reg(rcpm_pkg::RegWindow, 16'd2);
    hold_off_req = 1'b1;
    repeat (40) push_sample(pick_sample());
    drain();

    base_pushed = samples_pushed;
    while (samples_pushed - base_pushed < 470) begin
      if (samples_pushed - base_pushed >= 400) idle_on = 1'b0;
      if ($urandom_range(0, 1)) begin
        write_reg(rcpm_pkg::RegOffset, 16'($urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 1)) begin
        write_reg(rcpm_pkg::RegGain, 16'($urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 1)) begin
        w    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 100);
        word = {6'($urandom_range(0, 63)), 10'(w)};
        write_reg(rcpm_pkg::RegCorr, word);
      end
      if ($urandom_range(0, 1)) begin
        word = {7'($urandom_range(0, 127)), 9'($urandom_range(0, 511))};
        write_reg(rcpm_pkg::RegVolt, word);
      end
      if ($urandom_range(0, 7) == 0) write_reg(RegNone, 16'($urandom_range(0, 65535)));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: w = $urandom_range(1, 8);
        7, 8:                w = $urandom_range(9, 40);
        default:             w = $urandom_range(41, 120);
      endcase
      word = {3'($urandom_range(0, 7)), 13'(w)};
      write_reg(rcpm_pkg::RegWindow, word);
      n = $urandom_range(8, 48);
      repeat (n) push_sample(pick_sample());
      drain();
    end

    if (check_failures == 0 && !drain_stuck) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/rcpm_pkg.sv
src/rcpm_front.sv
src/rcpm_queue.sv
src/rcpm_back.sv
src/rms_current_power_meter_top.sv
tb/rms_meter_monitor.sv
tb/rms_current_power_meter_top_test.sv
